// ===== hw/rtl/tahw_pkg.sv =====
`default_nettype none

package tahw_pkg;

   localparam int unsigned ADDR_BITS   = 32;
   localparam int unsigned SIZE_DIGITS = 11;
   localparam int unsigned HDR_LEN     = 512;
   localparam int unsigned LAST_IDX    = HDR_LEN - 1;
   localparam int unsigned SIZE_POS    = 124;
   localparam int unsigned SIZE_END    = SIZE_POS + SIZE_DIGITS;
   localparam int unsigned TYPE_POS    = 156;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_FIVE  = 8'h35;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef logic [8:0]           hdr_idx_type;
   typedef logic [ADDR_BITS-1:0] offset_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_SKIP   = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ENTRY = 2'd0,
      KIND_TERM  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        archive_over;
      logic [31:0] header_offset;
      logic [31:0] data_address;
      logic [32:0] file_size;
      logic        dir_entry;
      logic        dot_slash_stripped;
      logic        name_empty;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tahw_if.sv =====
`default_nettype none

interface tahw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tahw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        archive_over;
   logic [31:0] header_offset;
   logic [31:0] data_address;
   logic [32:0] file_size;
   logic        dir_entry;
   logic        dot_slash_stripped;
   logic        name_empty;

   modport source (output valid, output kind, output archive_over, output header_offset,
                   output data_address, output file_size, output dir_entry,
                   output dot_slash_stripped, output name_empty, input ready);
   modport sink   (input valid, input kind, input archive_over, input header_offset,
                   input data_address, input file_size, input dir_entry,
                   input dot_slash_stripped, input name_empty, output ready);
endinterface

interface tahw_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] base_address;

   modport source (output valid, output base_address, input ready);
   modport sink   (input valid, input base_address, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tar_archive_header_walker_top.sv =====
// Walks a tar archive image presented one byte per beat on req_ch (data_byte,
// last_byte set on the final byte of the region). Each 512-byte header yields
// one beat on rsp_ch when its last byte arrives: header offset, data address
// (base_address + offset + 512), octal size, directory flag and the "./" name
// flags. The file data after a header is skipped, rounded up to 512 bytes.
// A zero first header byte gives a terminator beat; a last byte that gives no
// other beat gives a stream-ended beat. Either, or an entry beat on the last byte,
// sets archive_over; later bytes are consumed without results until reset.
// csr_ch writes base_address; write it only while the walker is idle.
// Throughput: one byte per cycle while beats are taken. Latency: a result
// appears on rsp_ch in the cycle after the byte that causes it is taken. All
// byte work is a counter step, an add or a 33-bit shift-add between the state
// registers and the result register. The result register decouples the sides:
// while it holds a beat that is not taken, req_ch.ready is low; it stays high
// as long as the result side takes beats. Synchronous reset returns to the first
// header at offset zero with base_address cleared and the result register empty.
`default_nettype none

module tar_archive_header_walker_top (
   input  wire logic    clock,
   input  wire logic    reset,
   tahw_req_if.sink     req_ch,
   tahw_rsp_if.source   rsp_ch,
   tahw_csr_if.sink     csr_ch
);

   logic [31:0]           base_ff;
   tahw_pkg::offset_type  offset_ff, offset_in;
   tahw_pkg::phase_type   phase_ff, phase_in;
   tahw_pkg::hdr_idx_type idx_ff, idx_in;
   tahw_pkg::offset_type  entry_ff, entry_in;
   logic [32:0]           acc_ff, acc_in;
   logic                  oct_ff, oct_in;
   logic [33:0]           skip_ff, skip_in;
   logic [23:0]           lead_ff, lead_in;
   logic                  dir_ff, dir_in;
   logic                  rsp_valid_ff;
   tahw_pkg::rsp_type     rsp_ff, res;

   logic                  accept, active, first, is_term, hdr_end, emit;
   tahw_pkg::offset_type  entry_eff, offset_inc, data_addr;
   logic [32:0]           acc_eff;
   logic                  oct_eff;
   logic [23:0]           lead_eff;
   logic                  dir_eff;
   logic [33:0]           skip_round, skip_next;
   logic                  strip;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign accept = req_ch.valid && req_ch.ready;
   assign active = accept && (phase_ff == tahw_pkg::PH_HEADER || phase_ff == tahw_pkg::PH_SKIP);

   // The first header byte opens a fresh entry, so the per-entry state reads
   // as its cleared value there instead of what the previous entry left.
   assign first     = (idx_ff == '0);
   assign entry_eff = first ? offset_ff : entry_ff;
   assign acc_eff   = first ? '0 : acc_ff;
   assign oct_eff   = first ? 1'b1 : oct_ff;
   assign lead_eff  = first ? '0 : lead_ff;
   assign dir_eff   = first ? 1'b0 : dir_ff;

   assign offset_inc = offset_ff + 1'b1;
   assign data_addr  = tahw_pkg::ADDR_BITS'(base_ff) + entry_eff
                     + tahw_pkg::ADDR_BITS'(tahw_pkg::HDR_LEN);
   assign is_term    = (phase_ff == tahw_pkg::PH_HEADER) && first
                     && (req_ch.data_byte == tahw_pkg::CHAR_NUL);
   assign hdr_end    = (phase_ff == tahw_pkg::PH_HEADER)
                     && (idx_ff == tahw_pkg::hdr_idx_type'(tahw_pkg::LAST_IDX));
   assign skip_round = ({1'b0, acc_eff} + 34'(tahw_pkg::LAST_IDX))
                     & ~34'(tahw_pkg::LAST_IDX);
   assign skip_next  = skip_ff - 1'b1;
   assign strip      = (lead_eff[7:0] == tahw_pkg::CHAR_DOT)
                     && (lead_eff[15:8] == tahw_pkg::CHAR_SLASH);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         priority if (is_term || req_ch.last_byte) begin
            phase_in = tahw_pkg::PH_DONE;
         end else if (hdr_end) begin
            phase_in = (skip_round != '0) ? tahw_pkg::PH_SKIP : tahw_pkg::PH_HEADER;
         end else if (phase_ff == tahw_pkg::PH_SKIP && skip_next == '0) begin
            phase_in = tahw_pkg::PH_HEADER;
         end else begin
            phase_in = phase_ff;
         end
      end
   end

   // Datapath updates and the result for the accepted byte.
   always_comb begin
      offset_in = offset_ff;
      idx_in    = idx_ff;
      entry_in  = entry_ff;
      acc_in    = acc_ff;
      oct_in    = oct_ff;
      skip_in   = skip_ff;
      lead_in   = lead_ff;
      dir_in    = dir_ff;
      emit      = 1'b0;
      res       = '0;
      if (active) begin
         offset_in = offset_inc;
         if (phase_ff == tahw_pkg::PH_HEADER) begin
            entry_in = entry_eff;
            acc_in   = acc_eff;
            oct_in   = oct_eff;
            lead_in  = lead_eff;
            dir_in   = dir_eff;
            if (idx_ff < 9'd3) begin
               lead_in[8*idx_ff[1:0] +: 8] = req_ch.data_byte;
            end
            if (idx_ff >= tahw_pkg::hdr_idx_type'(tahw_pkg::SIZE_POS)
                && idx_ff < tahw_pkg::hdr_idx_type'(tahw_pkg::SIZE_END) && oct_eff) begin
               if (req_ch.data_byte >= tahw_pkg::CHAR_ZERO
                   && req_ch.data_byte <= tahw_pkg::CHAR_SEVEN) begin
                  acc_in = {acc_eff[29:0], 3'b000} + 33'(req_ch.data_byte[2:0]);
               end else begin
                  oct_in = 1'b0;
               end
            end
            if (idx_ff == tahw_pkg::hdr_idx_type'(tahw_pkg::TYPE_POS)) begin
               dir_in = (req_ch.data_byte == tahw_pkg::CHAR_FIVE);
            end
            if (hdr_end) begin
               skip_in                = skip_round;
               idx_in                 = '0;
               emit                   = 1'b1;
               res.kind               = tahw_pkg::KIND_ENTRY;
               res.header_offset      = 32'(entry_eff);
               res.data_address       = 32'(data_addr);
               res.file_size          = acc_eff;
               res.dir_entry          = dir_eff;
               res.dot_slash_stripped = strip;
               res.name_empty         = strip && (lead_eff[23:16] == tahw_pkg::CHAR_NUL);
            end else begin
               idx_in = idx_ff + 1'b1;
            end
            if (is_term) begin
               emit              = 1'b1;
               res               = '0;
               res.kind          = tahw_pkg::KIND_TERM;
               res.archive_over  = 1'b1;
               res.header_offset = 32'(entry_eff);
               res.data_address  = 32'(data_addr);
            end
         end else begin
            skip_in = skip_next;
         end
         if (req_ch.last_byte) begin
            if (emit) begin
               res.archive_over = 1'b1;
            end else begin
               emit              = 1'b1;
               res.kind          = tahw_pkg::KIND_END;
               res.archive_over  = 1'b1;
               res.header_offset = 32'(offset_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         offset_ff    <= '0;
         phase_ff     <= tahw_pkg::PH_HEADER;
         idx_ff       <= '0;
         entry_ff     <= '0;
         acc_ff       <= '0;
         oct_ff       <= 1'b1;
         skip_ff      <= '0;
         lead_ff      <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            base_ff <= csr_ch.base_address;
         end
         offset_ff <= offset_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         entry_ff  <= entry_in;
         acc_ff    <= acc_in;
         oct_ff    <= oct_in;
         skip_ff   <= skip_in;
         lead_ff   <= lead_in;
         dir_ff    <= dir_in;
         if (!rsp_valid_ff || rsp_ch.ready) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ch.ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.kind               = rsp_ff.kind;
   assign rsp_ch.archive_over       = rsp_ff.archive_over;
   assign rsp_ch.header_offset      = rsp_ff.header_offset;
   assign rsp_ch.data_address       = rsp_ff.data_address;
   assign rsp_ch.file_size          = rsp_ff.file_size;
   assign rsp_ch.dir_entry          = rsp_ff.dir_entry;
   assign rsp_ch.dot_slash_stripped = rsp_ff.dot_slash_stripped;
   assign rsp_ch.name_empty         = rsp_ff.name_empty;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
   import tahw_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ENTRIES = 12;
   localparam int CSR_SETTLE     = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TAIL_BYTES     = 16;

   typedef enum int {
      STOP_ZERO_NAME,
      STOP_ON_ENTRY,
      STOP_CUT_HEADER,
      STOP_IN_DATA
   } stop_way_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tahw_req_if req_if ();
   tahw_rsp_if rsp_if ();
   tahw_csr_if csr_if ();

   tar_archive_header_walker_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Walker state as the testbench predicts it.
   logic [31:0] base_addr    = '0;
   offset_type  walk_offset  = '0;
   phase_type   walk_phase   = PH_HEADER;
   hdr_idx_type hdr_index    = '0;
   offset_type  entry_base   = '0;
   logic [32:0] size_acc     = '0;
   logic        octal_live   = 1'b1;
   logic [33:0] skip_left    = '0;
   logic [23:0] name_lead    = '0;
   logic        dir_seen     = 1'b0;

   rsp_type predicted_records [$];
   rsp_type want_rec;
   logic [7:0] hdr_img [HDR_LEN];
   int  fail_count   = 0;
   int  quiet_cycles = 0;
   bit  calm         = 1'b0;
   bit  hold_request = 1'b0;

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advances the predicted walker by one byte; returns 1 when the byte yields a result.
   function automatic bit walk_byte(input logic [7:0] b, input logic last, output rsp_type r);
      bit   hit;
      logic strip;
      hit = 1'b0;
      r   = '0;
      if (walk_phase == PH_DONE) return 1'b0;
      if (walk_phase == PH_HEADER) begin
         if (hdr_index == 0) begin
            entry_base = walk_offset;
            size_acc   = '0;
            octal_live = 1'b1;
            name_lead  = '0;
            dir_seen   = 1'b0;
         end
         if (hdr_index < 3) name_lead[8*hdr_index +: 8] = b;
         if (hdr_index == 0 && b == CHAR_NUL) begin
            r.kind          = KIND_TERM;
            r.archive_over  = 1'b1;
            r.header_offset = entry_base;
            r.data_address  = base_addr + entry_base + 32'(HDR_LEN);
            walk_phase      = PH_DONE;
            walk_offset     = walk_offset + 1'b1;
            return 1'b1;
         end
         if (hdr_index >= SIZE_POS && hdr_index < SIZE_END && octal_live) begin
            if (b >= CHAR_ZERO && b <= CHAR_SEVEN) size_acc = {size_acc[29:0], 3'(b - CHAR_ZERO)};
            else octal_live = 1'b0;
         end
         if (hdr_index == TYPE_POS) dir_seen = (b == CHAR_FIVE);
         if (hdr_index == LAST_IDX) begin
            strip                = name_lead[7:0] == CHAR_DOT && name_lead[15:8] == CHAR_SLASH;
            r.kind               = KIND_ENTRY;
            r.header_offset      = entry_base;
            r.data_address       = base_addr + entry_base + 32'(HDR_LEN);
            r.file_size          = size_acc;
            r.dir_entry          = dir_seen;
            r.dot_slash_stripped = strip;
            r.name_empty         = strip && name_lead[23:16] == CHAR_NUL;
            hit                  = 1'b1;
            skip_left            = ({1'b0, size_acc} + 34'd511) & ~34'd511;
            walk_phase           = (skip_left != 0) ? PH_SKIP : PH_HEADER;
            hdr_index            = '0;
         end else begin
            hdr_index = hdr_index + 1'b1;
         end
      end else begin
         skip_left = skip_left - 1'b1;
         if (skip_left == 0) walk_phase = PH_HEADER;
      end
      walk_offset = walk_offset + 1'b1;
      if (last) begin
         walk_phase = PH_DONE;
         if (!hit) begin
            r               = '0;
            r.kind          = KIND_END;
            r.header_offset = walk_offset;
            hit             = 1'b1;
         end
         r.archive_over = 1'b1;
      end
      return hit;
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int      gap;
      rsp_type rec;
      gap = pick_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= value;
      req_if.last_byte <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (walk_byte(value, last, rec)) predicted_records.push_back(rec);
   endtask

   // The block must be idle for a write, so the byte stream is paused first.
   task automatic write_base(input logic [31:0] value);
      req_if.valid <= 1'b0;
      while (predicted_records.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_if.valid        <= 1'b1;
      csr_if.base_address <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      base_addr = value;
   endtask

   function automatic logic [7:0] non_octal();
      logic [7:0] b;
      do b = 8'($urandom); while (b >= CHAR_ZERO && b <= CHAR_SEVEN);
      return b;
   endfunction

   function automatic void prep_header(input logic [7:0] c0, c1, c2, input string size_txt,
                                       input logic [7:0] size_stop, input logic [7:0] type_char);
      for (int i = 0; i < HDR_LEN; i++) hdr_img[i] = 8'($urandom);
      hdr_img[0] = c0;
      hdr_img[1] = c1;
      hdr_img[2] = c2;
      for (int i = 0; i < size_txt.len() && i < SIZE_DIGITS; i++) hdr_img[SIZE_POS + i] = size_txt[i];
      if (size_txt.len() < SIZE_DIGITS) hdr_img[SIZE_POS + size_txt.len()] = size_stop;
      hdr_img[TYPE_POS] = type_char;
   endfunction

   function automatic void random_header();
      logic [7:0] c0, c1, c2, tf, stop;
      string      sz;
      int         pick;
      pick = $urandom_range(0, 9);
      c0   = 8'($urandom_range(1, 255));
      c1   = 8'($urandom);
      c2   = ($urandom_range(0, 2) == 0) ? CHAR_NUL : 8'($urandom);
      if (pick < 4) begin
         c0 = CHAR_DOT;
         c1 = CHAR_SLASH;
         if (pick == 3) c2 = CHAR_NUL;
      end else if (pick == 4) begin
         c0 = CHAR_DOT;
      end
      stop = non_octal();
      pick = $urandom_range(0, 9);
      if (pick < 6) sz = $sformatf("%011o", $urandom_range(0, 700));
      else if (pick < 8) sz = $sformatf("%0o", $urandom_range(0, 700));
      else if (pick == 8) sz = "";
      else sz = $sformatf("%011o", $urandom_range(0, 511));
      pick = $urandom_range(0, 9);
      tf   = (pick < 3) ? CHAR_FIVE : (pick < 6) ? CHAR_ZERO : 8'($urandom);
      prep_header(c0, c1, c2, sz, stop, tf);
   endfunction

   // Sends the prepared header and then whatever file data it announces.
   task automatic send_entry(input bit hold_result);
      for (int i = 0; i < HDR_LEN; i++) begin
         if (hold_result && i == HDR_LEN - 112) hold_request = 1'b1;
         send_byte(hdr_img[i], 1'b0);
      end
      while (walk_phase == PH_SKIP) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic test_base_address();
      write_base(32'hFFFF_FFFF);
      random_header();
      send_entry(1'b0);
      write_base(32'hFFFF_FE00);
      random_header();
      send_entry(1'b0);
      write_base(32'h8000_0000);
      random_header();
      send_entry(1'b0);
      write_base(32'h0000_0000);
      random_header();
      send_entry(1'b0);
   endtask

   task automatic test_size_field();
      prep_header(8'h61, 8'h62, 8'h63, "00000000000", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "00000000777", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "00000001001", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      // An octal digit right after the eleventh one must not extend the size.
      prep_header(8'h61, 8'h62, 8'h63, "00000000001", CHAR_NUL, CHAR_ZERO);
      hdr_img[SIZE_END] = CHAR_SEVEN;
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "17", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "", 8'h38, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "12", 8'h2F, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "3210", 8'h20, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h61, 8'h62, 8'h63, "0000000200", 8'h38, CHAR_ZERO);
      send_entry(1'b0);
   endtask

   task automatic test_name_flags();
      prep_header(CHAR_DOT, CHAR_SLASH, CHAR_NUL, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(CHAR_DOT, CHAR_SLASH, 8'h61, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(CHAR_DOT, CHAR_SLASH, 8'hFF, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(CHAR_DOT, CHAR_DOT, CHAR_NUL, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(CHAR_SLASH, CHAR_DOT, CHAR_SLASH, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'hFF, 8'hFF, 8'hFF, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
      prep_header(8'h01, CHAR_NUL, CHAR_NUL, "0", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b0);
   endtask

   task automatic test_typeflag();
      prep_header(8'h64, 8'h69, 8'h72, "0", CHAR_NUL, CHAR_FIVE);
      send_entry(1'b0);
      prep_header(8'h64, 8'h69, 8'h72, "0", CHAR_NUL, 8'h34);
      send_entry(1'b0);
      prep_header(8'h64, 8'h69, 8'h72, "0", CHAR_NUL, 8'h36);
      send_entry(1'b0);
      prep_header(8'h64, 8'h69, 8'h72, "0", CHAR_NUL, CHAR_NUL);
      send_entry(1'b0);
      prep_header(8'h64, 8'h69, 8'h72, "0", CHAR_NUL, 8'hFF);
      send_entry(1'b0);
   endtask

   // The result side stalls long enough for the result register to fill and block input.
   task automatic test_backpressure();
      prep_header(8'h70, 8'h71, 8'h72, "00000001000", CHAR_NUL, CHAR_ZERO);
      send_entry(1'b1);
      random_header();
      send_entry(1'b0);
   endtask

   task automatic test_random_archive();
      for (int h = 0; h < RANDOM_ENTRIES; h++) begin
         if (h % 8 == 7) begin
            case ($urandom_range(0, 2))
               0:       write_base(32'h0000_0000);
               1:       write_base(32'hFFFF_FFFF);
               default: write_base($urandom);
            endcase
         end
         calm = ($urandom_range(0, 4) == 0);
         random_header();
         send_entry(1'b0);
      end
      calm = 1'b0;
   endtask

   // Only one way of ending the archive fits in a run; the seed picks which.
   task automatic test_stop();
      stop_way_type way;
      int           cut;
      way = stop_way_type'($urandom_range(0, 3));
      case (way)
         STOP_ZERO_NAME: begin
            send_byte(CHAR_NUL, 1'($urandom_range(0, 1)));
         end
         STOP_ON_ENTRY, STOP_CUT_HEADER: begin
            random_header();
            cut = (way == STOP_ON_ENTRY) ? LAST_IDX : $urandom_range(0, LAST_IDX - 1);
            for (int i = 0; i < cut; i++) send_byte(hdr_img[i], 1'b0);
            send_byte(hdr_img[cut], 1'b1);
         end
         default: begin
            prep_header(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom),
                        "77777777777", CHAR_NUL, CHAR_ZERO);
            for (int i = 0; i < HDR_LEN; i++) send_byte(hdr_img[i], 1'b0);
            repeat ($urandom_range(0, 600)) send_byte(8'($urandom), 1'b0);
            send_byte(8'($urandom), 1'b1);
         end
      endcase
      // After the walker has stopped, bytes are consumed with no result.
      repeat (TAIL_BYTES) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
   endtask

   function automatic void check_field(input string name, input logic [32:0] want,
                                       input logic [32:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (predicted_records.size() == 0) begin
            $error("result beat with no prediction pending: kind %0h offset %0h",
                   rsp_if.kind, rsp_if.header_offset);
            fail_count++;
         end else begin
            want_rec = predicted_records.pop_front();
            check_field("kind", want_rec.kind, rsp_if.kind);
            check_field("archive_over", want_rec.archive_over, rsp_if.archive_over);
            check_field("header_offset", want_rec.header_offset, rsp_if.header_offset);
            check_field("data_address", want_rec.data_address, rsp_if.data_address);
            check_field("file_size", want_rec.file_size, rsp_if.file_size);
            check_field("dir_entry", want_rec.dir_entry, rsp_if.dir_entry);
            check_field("dot_slash_stripped", want_rec.dot_slash_stripped,
                        rsp_if.dot_slash_stripped);
            check_field("name_empty", want_rec.name_empty, rsp_if.name_empty);
         end
      end
   end

   initial begin : result_sink
      int gap;
      rsp_if.ready = 1'b0;
      forever begin
         gap = pick_gap();
         if (hold_request) begin
            gap          = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (gap != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      req_if.valid        = 1'b0;
      req_if.data_byte    = '0;
      req_if.last_byte    = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.base_address = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_base_address();
      test_size_field();
      test_name_flags();
      test_typeflag();
      test_backpressure();
      test_random_archive();
      test_stop();
      req_if.valid <= 1'b0;
      while (predicted_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
